[rtl/dra_pkg.sv]
// Shared types and constants of the dense rank assigner.
`default_nettype none
package dra_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    // Default list capacity
    localparam int DRA_MAX_ITEMS = 32;

    // Controller phases
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RING,
        ST_EMIT
    } t_state;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic load;    // a word is being stored this cycle
        logic rotate;  // move tokens one cell along the ring
        logic emit;    // move ranks one cell toward the head
        logic clear;   // drop all tokens, list is done
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/dra_cell.sv]
// One cell of the rank chain: stored value, circulating token and rank counter.
`default_nettype none
module dra_cell
    import dra_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic               i_we,
    input  wire logic               i_in_use,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_first_new,
    input  wire logic [VALUE_W-1:0] i_tok,
    input  wire logic               i_tok_first,
    input  wire logic [RANK_W-1:0]  i_rank_next,
    output logic                    o_eq,
    output logic [VALUE_W-1:0]      o_tok,
    output logic                    o_tok_first,
    output logic [RANK_W-1:0]       o_rank
);

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] r_tok;
    logic               r_tok_first;
    logic [RANK_W-1:0]  r_rank;
    logic               n_tok_first;
    logic               tok_less;

    // Flag a stored duplicate of the incoming word
    assign o_eq = i_in_use && (r_val == i_value);

    // Count tokens of distinct values below the stored one
    assign tok_less = r_tok_first && ($signed(r_tok) < $signed(r_val));

    // Select next token flag
    always_comb begin
        n_tok_first = r_tok_first;
        if (i_ctl.clear) begin
            n_tok_first = 1'b0;
        end else if (i_ctl.load && i_we) begin
            n_tok_first = i_first_new;
        end else if (i_ctl.rotate) begin
            n_tok_first = i_tok_first;
        end
    end

    // Hold token flag, cleared between lists
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_first <= 1'b0;
        end else begin
            r_tok_first <= n_tok_first;
        end
    end

    // Store value, pass tokens and ranks along
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_we) begin
            r_val  <= i_value;
            r_tok  <= i_value;
            r_rank <= RANK_W'(1);
        end else if (i_ctl.rotate) begin
            r_tok <= i_tok;
            if (tok_less) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end else if (i_ctl.emit) begin
            r_rank <= i_rank_next;
        end
    end

    assign o_tok       = r_tok;
    assign o_tok_first = r_tok_first;
    assign o_rank      = r_rank;

endmodule
`default_nettype wire

[rtl/dense_rank_assign.sv]
// Top level of the dense rank assigner: controller and chain of cells.
`default_nettype none
// Loads one signed word per cycle while busy is low; the word with i_is_last
// high closes the list. Each word is kept in a cell of its own, together with a
// flag telling whether it is the first of its value. After the last word the
// cells pass their words once around the ring, each cell counting the distinct
// smaller values that go by; the ranks then shift out of the head cell, one per
// cycle, in input order, with o_valid high for exactly one cycle each. Busy
// stays high from the last word through the token ring and the rank shift.
// Results cannot be held off: capture every cycle o_valid is high.
// Words beyond MAX_ITEMS are dropped and o_overflow is set on every rank.
module dense_rank_assign
    import dra_pkg::*;
#(
    parameter int MAX_ITEMS = DRA_MAX_ITEMS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_is_last,
    output logic                    o_valid,
    output logic [RANK_W-1:0]       o_rank,
    output logic                    o_end_of_list,
    output logic                    o_overflow
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int STEP_W = $clog2(MAX_ITEMS);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic [STEP_W-1:0] r_step, n_step;
    logic             r_ovf, n_ovf;

    t_cell_ctl        ctl;
    logic             accept;
    logic             full;
    logic             ring_done;
    logic             emit_done;
    logic             first_new;

    logic [MAX_ITEMS-1:0]              eq;
    logic [MAX_ITEMS-1:0]              tok_first;
    logic [MAX_ITEMS-1:0][VALUE_W-1:0] tok;
    logic [MAX_ITEMS-1:0][RANK_W-1:0]  rank;

    assign accept    = start && !busy;
    assign full      = (r_count == CNT_W'(MAX_ITEMS));
    assign ring_done = (r_step == STEP_W'(MAX_ITEMS - 1));
    assign emit_done = (r_left == CNT_W'(1));
    assign first_new = ~|eq;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (accept && i_is_last) n_state = ST_RING;
            ST_RING: if (ring_done) n_state = ST_EMIT;
            ST_EMIT: if (emit_done) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // Outputs and cell commands
    always_comb begin
        busy          = 1'b1;
        o_valid       = 1'b0;
        o_end_of_list = 1'b0;
        ctl           = '0;
        unique case (r_state)
            ST_LOAD: begin
                busy     = 1'b0;
                ctl.load = start && !full;
            end
            ST_RING: begin
                ctl.rotate = 1'b1;
            end
            ST_EMIT: begin
                o_valid       = 1'b1;
                o_end_of_list = emit_done;
                ctl.emit      = 1'b1;
                ctl.clear     = emit_done;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_rank     = rank[0];
    assign o_overflow = r_ovf;

    // Advance counters
    always_comb begin
        n_count = r_count;
        n_left  = r_left;
        n_step  = r_step;
        n_ovf   = r_ovf;
        priority if (ctl.clear) begin
            n_count = '0;
            n_ovf   = 1'b0;
            n_left  = '0;
        end else if (ctl.emit) begin
            n_left = r_left - CNT_W'(1);
        end else if (ctl.rotate) begin
            n_step = r_step + STEP_W'(1);
            n_left = r_count;
        end else if (accept) begin
            n_step = '0;
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_left  <= '0;
            r_step  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_step  <= n_step;
            r_ovf   <= n_ovf;
        end
    end

    // Chain of cells, tokens wrap from the tail to the head
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? MAX_ITEMS - 1 : g - 1;
        logic [RANK_W-1:0] rank_next;
        if (g == MAX_ITEMS - 1) begin : g_tail
            assign rank_next = '0;
        end else begin : g_body
            assign rank_next = rank[g + 1];
        end
        dra_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_we        (r_count == CNT_W'(g)),
            .i_in_use    (CNT_W'(g) < r_count),
            .i_value     (i_value),
            .i_first_new (first_new),
            .i_tok       (tok[PREV]),
            .i_tok_first (tok_first[PREV]),
            .i_rank_next (rank_next),
            .o_eq        (eq[g]),
            .o_tok       (tok[g]),
            .o_tok_first (tok_first[g]),
            .o_rank      (rank[g])
        );
    end

`ifndef SYNTHESIS
    // Fill count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    // Every rank drawn from a stored word
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_left != '0) && (r_left <= r_count))
        else $error("rank emitted with no stored word left");

    // Closing word starts the rank pass
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_is_last) |=> busy && !o_valid)
        else $error("closing word did not start the ring pass");

    // Nothing follows the last rank of a list
    a_end_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_list |=> !o_valid && !busy && (r_count == '0))
        else $error("output continued past end of list");
`endif

endmodule
`default_nettype wire

[sim/dense_rank_checker.sv]
// Checker of the dense rank assigner: tracks loaded words, predicts ranks, compares results.
module dense_rank_checker
    import dra_pkg::*;
#(
    parameter int LIST_CAP = DRA_MAX_ITEMS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_is_last,
    input  wire logic               o_valid,
    input  wire logic [RANK_W-1:0]  o_rank,
    input  wire logic               o_end_of_list,
    input  wire logic               o_overflow,
    output int                      fail_count,
    output int                      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              end_of_list;
        logic              overflow;
    } t_rank_word;

    // Shadow copy of the list being loaded
    logic signed [VALUE_W-1:0] held_words [LIST_CAP];
    int                        held_count;
    logic                      held_dropped;

    // Ranks still owed by the block, oldest first
    t_rank_word                rank_q [$];
    int                        result_index;
    int                        step_fails;

    // Count distinct held values below entry idx, each value counted at its first entry
    function automatic logic [RANK_W-1:0] dense_rank_of(int idx);
        int smaller;
        bit first_seen;
        smaller = 0;
        for (int j = 0; j < held_count; j++) begin
            first_seen = 1'b1;
            for (int k = 0; k < j; k++) begin
                if (held_words[k] == held_words[j])
                    first_seen = 1'b0;
            end
            if (first_seen && (held_words[j] < held_words[idx]))
                smaller++;
        end
        return RANK_W'(smaller + 1);
    endfunction

    // Store or drop one word; on the closing word queue a rank per held entry
    task automatic store_word(input logic [VALUE_W-1:0] v, input logic last);
        t_rank_word w;
        if (held_count < LIST_CAP) begin
            held_words[held_count] = v;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < held_count; i++) begin
                w.rank        = dense_rank_of(i);
                w.end_of_list = (i == held_count - 1);
                w.overflow    = held_dropped;
                rank_q.push_back(w);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    // Compare one result word against the oldest expectation
    task automatic check_rank_word(output int fails);
        t_rank_word want;
        fails = 0;
        if (rank_q.size() == 0) begin
            $display("%0t: unexpected rank word %0d: rank %0d end_of_list %0b overflow %0b",
                     $time, result_index, o_rank, o_end_of_list, o_overflow);
            fails = 1;
        end else begin
            want = rank_q.pop_front();
            if (o_rank !== want.rank) begin
                $display("%0t: rank word %0d: rank expected %0d, actual %0d",
                         $time, result_index, want.rank, o_rank);
                fails++;
            end
            if (o_end_of_list !== want.end_of_list) begin
                $display("%0t: rank word %0d: end_of_list expected %0b, actual %0b",
                         $time, result_index, want.end_of_list, o_end_of_list);
                fails++;
            end
            if (o_overflow !== want.overflow) begin
                $display("%0t: rank word %0d: overflow expected %0b, actual %0b",
                         $time, result_index, want.overflow, o_overflow);
                fails++;
            end
        end
        result_index++;
    endtask

    // Watch both channels at every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count   = 0;
            held_dropped = 1'b0;
            result_index = 0;
            rank_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            step_fails = 0;
            if (o_valid)
                check_rank_word(step_fails);
            if (start && !busy)
                store_word(i_value, i_is_last);
            fail_count    <= fail_count + step_fails;
            pending_count <= rank_q.size();
        end
    end

endmodule

[sim/dense_rank_assign_tb.sv]
// Top of the dense rank assigner testbench: clock, reset, list stimulus and verdict.
module dense_rank_assign_tb
    import dra_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP     = DRA_MAX_ITEMS;
    localparam int RANDOM_ITEMS = 430;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * LIST_CAP + 16;

    logic               i_clk;
    logic               i_rst_n   = 1'b0;
    logic               start     = 1'b0;
    logic [VALUE_W-1:0] i_value   = '0;
    logic               i_is_last = 1'b0;
    logic               busy;
    logic               o_valid;
    logic [RANK_W-1:0]  o_rank;
    logic               o_end_of_list;
    logic               o_overflow;
    int                 fail_count;
    int                 pending_count;

    int                 burst_left = 0;
    int                 quiet_cycles = 0;
    int                 stored_items;
    logic [VALUE_W-1:0] list_words [64];

    dense_rank_assign u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .o_rank        (o_rank),
        .o_end_of_list (o_end_of_list),
        .o_overflow    (o_overflow)
    );

    dense_rank_checker #(
        .LIST_CAP (LIST_CAP)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .o_rank        (o_rank),
        .o_end_of_list (o_end_of_list),
        .o_overflow    (o_overflow),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one word at a falling edge, hold it until the block takes it
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        start     <= 1'b1;
        i_value   <= v;
        i_is_last <= last;
        do @(posedge i_clk); while (busy);
    endtask

    // Draw a list element; some modes favor duplicates and extremes
    function automatic logic [VALUE_W-1:0] pick_value(int mode, int pos);
        logic [VALUE_W-1:0] v;
        case (mode)
            1: v = VALUE_W'($signed($urandom_range(0, 6)) - 3);
            2: begin
                if (pos > 0 && $urandom_range(0, 1) == 1)
                    v = list_words[$urandom_range(0, pos - 1)];
                else
                    v = $urandom;
            end
            3: begin
                case ($urandom_range(0, 6))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h8000_0001;
                    5: v = 32'h7FFF_FFFE;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Send a whole list of len words, the last one closing it
    task automatic run_list(input int len);
        int mode;
        logic [VALUE_W-1:0] v;
        mode = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            v = pick_value(mode, k);
            list_words[k] = v;
            send_word(v, k == len - 1);
            if (k < LIST_CAP)
                stored_items++;
        end
    endtask

    initial begin
        int len;
        int r;
        int list_no;

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-word list
        send_word(32'h0000_0000, 1'b1);
        // Extremes with a duplicate of the most negative value
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        // All equal: every rank is one
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b1);
        // Descending order
        send_word(32'd3, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd1, 1'b1);
        // Signed order across the sign boundary
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);

        // Random lists; open with an exactly full list and one whose closing word is dropped
        stored_items = 0;
        list_no = 0;
        while (stored_items < RANDOM_ITEMS) begin
            case (list_no)
                0: len = LIST_CAP;
                1: len = LIST_CAP + 2;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        len = $urandom_range(1, 8);
                    else if (r < 85)
                        len = $urandom_range(9, LIST_CAP - 1);
                    else if (r < 92)
                        len = LIST_CAP;
                    else
                        len = $urandom_range(LIST_CAP + 1, LIST_CAP + 8);
                end
            endcase
            run_list(len);
            list_no++;
        end

        // Drain outstanding ranks, then let the block settle
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
